// ----- sv/dolp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and the option size rule for the DHCP option lookup parser.
// No dependencies.
package dolp_pkg;

    localparam int AREA_BYTES_DEFAULT = 312;

    // Configuration register indexes
    localparam logic [0:0] CFG_WANTED_CODE = 1'b0;
    localparam logic [0:0] CFG_COPY_LIMIT  = 1'b1;

    localparam logic [7:0] WANTED_CODE_RESET = 8'd53;
    localparam logic [7:0] COPY_LIMIT_RESET  = 8'd255;

    localparam logic [7:0] CODE_PAD = 8'h00;
    localparam logic [7:0] CODE_END = 8'hff;

    localparam int COOKIE_LAST = 3;

    // Verdict codes
    localparam logic [2:0] ST_SEARCH   = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_BADSIZE  = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_COOKIE = 3'd1,
        PH_CODE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_SKIP   = 3'd4,
        PH_VALUE  = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] value_byte;
        logic       value_valid;
        logic       value_last;
        logic [7:0] option_length;
    } res_t;

    function automatic logic size_fits(input logic [7:0] code, input logic [7:0] len);
        logic ok;
        begin
            case (code)
                8'd53:   ok = (len == 8'd1);
                8'd15:   ok = (len != 8'd0);
                8'd1, 8'd28, 8'd51, 8'd54, 8'd58, 8'd59:
                         ok = (len == 8'd4);
                8'd3, 8'd6:
                         ok = (len != 8'd0) && (len[1:0] == 2'b00);
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

// ----- sv/dolp_core.sv -----
`timescale 1ns / 1ps
// Parse state, configuration registers and the per-word step logic.
// Depends on dolp_pkg.
module dolp_core #(
    parameter int AREA_BYTES = dolp_pkg::AREA_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              fire,
    input  logic [7:0]        opt_byte,
    input  logic              start_req,
    input  logic              area_end,
    output dolp_pkg::res_t    res
);

    localparam int POS_W = $clog2(AREA_BYTES);
    localparam int SUM_W = ((POS_W > 8) ? POS_W : 8) + 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(AREA_BYTES - 1);
    localparam logic [POS_W-1:0] COOKIE_POS = POS_W'(dolp_pkg::COOKIE_LAST);

    logic [7:0]       wanted_code_reg;
    logic [7:0]       copy_limit_reg;
    dolp_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       copied_reg, copied_next;
    logic             match_reg, match_next;
    logic [7:0]       flen_reg, flen_next;

    dolp_pkg::phase_t phase_e;
    logic [POS_W-1:0] pos_e;
    logic [7:0]       rem_e, copied_e, flen_e;
    logic             match_e;
    logic             active, at_end, is_term, hit, len_over, size_ok, copy_ok;
    logic [7:0]       rem_dec, copied_inc;
    logic [SUM_W-1:0] rec_end;
    logic [2:0]       step_status;

    // Start of a new area overrides whatever search was running
    assign phase_e  = start_req ? dolp_pkg::PH_COOKIE : phase_reg;
    assign pos_e    = start_req ? '0 : pos_reg;
    assign rem_e    = start_req ? 8'd0 : rem_reg;
    assign copied_e = start_req ? 8'd0 : copied_reg;
    assign match_e  = start_req ? 1'b0 : match_reg;
    assign flen_e   = start_req ? 8'd0 : flen_reg;

    assign active     = (phase_e != dolp_pkg::PH_IDLE) && (phase_e != dolp_pkg::PH_DONE);
    assign at_end     = area_end || (pos_e >= LAST_POS);
    assign is_term    = (opt_byte == dolp_pkg::CODE_PAD) || (opt_byte == dolp_pkg::CODE_END);
    assign hit        = (opt_byte == wanted_code_reg);
    assign rec_end    = SUM_W'(pos_e) + SUM_W'(opt_byte);
    assign len_over   = (rec_end > SUM_W'(AREA_BYTES - 1)) || (area_end && (opt_byte != 8'd0));
    assign size_ok    = dolp_pkg::size_fits(wanted_code_reg, opt_byte) && (opt_byte != 8'd0);
    assign rem_dec    = (rem_e != 8'd0) ? (rem_e - 8'd1) : 8'd0;
    assign copy_ok    = (copied_e < copy_limit_reg);
    assign copied_inc = copied_e + 8'd1;

    // Result of this word
    always_comb
    begin
        step_status = dolp_pkg::ST_SEARCH;
        res         = '0;
        case (phase_e)
            dolp_pkg::PH_COOKIE:
            begin
                if (at_end)
                    step_status = dolp_pkg::ST_NOTFOUND;
            end
            dolp_pkg::PH_CODE:
            begin
                if (is_term)
                    step_status = dolp_pkg::ST_NOTFOUND;
                else if (hit)
                    step_status = at_end ? dolp_pkg::ST_OVERRUN : dolp_pkg::ST_SEARCH;
                else if (at_end)
                    step_status = dolp_pkg::ST_NOTFOUND;
            end
            dolp_pkg::PH_LEN:
            begin
                if (match_e)
                begin
                    if (len_over)
                        step_status = dolp_pkg::ST_OVERRUN;
                    else if (!size_ok)
                        step_status = dolp_pkg::ST_BADSIZE;
                end
                else if (at_end)
                    step_status = dolp_pkg::ST_NOTFOUND;
            end
            dolp_pkg::PH_SKIP:
            begin
                if (at_end)
                    step_status = dolp_pkg::ST_NOTFOUND;
            end
            dolp_pkg::PH_VALUE:
            begin
                if ((rem_e > 8'd1) && at_end)
                    step_status = dolp_pkg::ST_OVERRUN;
                else
                begin
                    if (copy_ok)
                    begin
                        res.value_byte  = opt_byte;
                        res.value_valid = 1'b1;
                        res.value_last  = (rem_dec == 8'd0) || (copied_inc == copy_limit_reg);
                    end
                    if (rem_dec == 8'd0)
                        step_status = dolp_pkg::ST_OK;
                end
            end
            default:
            begin
                step_status = dolp_pkg::ST_SEARCH;
            end
        endcase
        res.status        = step_status;
        res.option_length = match_next ? flen_next : 8'd0;
        if (!active)
            res = '0;
    end

    // Next parse state
    always_comb
    begin
        phase_next  = phase_e;
        pos_next    = pos_e;
        rem_next    = rem_e;
        copied_next = copied_e;
        match_next  = match_e;
        flen_next   = flen_e;
        case (phase_e)
            dolp_pkg::PH_COOKIE:
            begin
                if (pos_e >= COOKIE_POS)
                    phase_next = dolp_pkg::PH_CODE;
            end
            dolp_pkg::PH_CODE:
            begin
                if (!is_term)
                begin
                    if (hit)
                        match_next = 1'b1;
                    if (!at_end)
                        phase_next = dolp_pkg::PH_LEN;
                end
            end
            dolp_pkg::PH_LEN:
            begin
                if (match_e)
                begin
                    flen_next = opt_byte;
                    if (!len_over && size_ok)
                    begin
                        rem_next    = opt_byte;
                        copied_next = 8'd0;
                        phase_next  = dolp_pkg::PH_VALUE;
                    end
                end
                else if (!at_end)
                begin
                    if (opt_byte == 8'd0)
                        phase_next = dolp_pkg::PH_CODE;
                    else
                    begin
                        rem_next   = opt_byte;
                        phase_next = dolp_pkg::PH_SKIP;
                    end
                end
            end
            dolp_pkg::PH_SKIP:
            begin
                rem_next = rem_dec;
                if (!at_end && (rem_dec == 8'd0))
                    phase_next = dolp_pkg::PH_CODE;
            end
            dolp_pkg::PH_VALUE:
            begin
                if (!((rem_e > 8'd1) && at_end))
                begin
                    rem_next = rem_dec;
                    if (copy_ok)
                        copied_next = copied_inc;
                end
            end
            default:
            begin
                phase_next = phase_e;
            end
        endcase
        if (active)
        begin
            if (step_status != dolp_pkg::ST_SEARCH)
                phase_next = dolp_pkg::PH_DONE;
            if (pos_e < LAST_POS)
                pos_next = pos_e + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_code_reg <= dolp_pkg::WANTED_CODE_RESET;
            copy_limit_reg  <= dolp_pkg::COPY_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dolp_pkg::CFG_WANTED_CODE: wanted_code_reg <= cfg_wdata;
                dolp_pkg::CFG_COPY_LIMIT:  copy_limit_reg  <= cfg_wdata;
                default:                   copy_limit_reg  <= copy_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dolp_pkg::PH_IDLE;
            pos_reg    <= '0;
            rem_reg    <= 8'd0;
            copied_reg <= 8'd0;
            match_reg  <= 1'b0;
            flen_reg   <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            copied_reg <= copied_next;
            match_reg  <= match_next;
            flen_reg   <= flen_next;
        end
    end

    a_pos_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position past area");

    a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (step_status != dolp_pkg::ST_SEARCH) |=> phase_reg == dolp_pkg::PH_DONE)
        else $error("verdict did not close search");

    a_hold_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !start_req && (phase_reg == dolp_pkg::PH_DONE) |=>
            phase_reg == dolp_pkg::PH_DONE)
        else $error("search resumed without start");

    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.value_valid |-> (res.status == dolp_pkg::ST_SEARCH) ||
            (res.status == dolp_pkg::ST_OK))
        else $error("value byte with failing verdict");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !start_req && ((phase_reg == dolp_pkg::PH_IDLE) || (phase_reg == dolp_pkg::PH_DONE))
            |-> (res == '0))
        else $error("ignored byte gave nonzero result");

endmodule

// ----- sv/dolp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register with handshake; takes a new word while the held one drains.
// Depends on dolp_pkg.
module dolp_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  dolp_pkg::res_t d,
    output logic           can_load,
    output logic           m_valid,
    input  logic           m_ready,
    output dolp_pkg::res_t q
);

    logic           valid_reg, valid_next;
    dolp_pkg::res_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= d;
    end

    assign m_valid = valid_reg;
    assign q       = data_reg;

endmodule

// ----- sv/dhcp_option_lookup_parser_top.sv -----
`timescale 1ns / 1ps
// DHCP option lookup parser: walks an options area one byte per word and reports the
// wanted option's verdict, length and value bytes. Depends on dolp_pkg, dolp_core, dolp_out_reg.
//
// One byte per cycle, with one result word per input word, held in a result register;
// the parse state is registered and that result register decouples the output, so
// input is taken every cycle while the output side keeps up. The user must write configuration
// (wanted_code index 0, copy_limit index 1) only between areas; the block does not check it.
module dhcp_option_lookup_parser_top #(
    parameter int AREA_BYTES = dolp_pkg::AREA_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] opt_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_req
    input  logic        s_axis_tlast,   // area_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [15:8] option_length
    output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] value_valid
    output logic        m_axis_tlast    // value_last
);

    logic           fire;
    logic           can_load;
    dolp_pkg::res_t step_res;
    dolp_pkg::res_t out_res;

    assign s_axis_tready = can_load;
    assign fire          = s_axis_tvalid && can_load;

    dolp_core #(
        .AREA_BYTES(AREA_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .opt_byte  (s_axis_tdata),
        .start_req (s_axis_tuser[0]),
        .area_end  (s_axis_tlast),
        .res       (step_res)
    );

    dolp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .d        (step_res),
        .can_load (can_load),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .q        (out_res)
    );

    assign m_axis_tdata = {out_res.option_length, out_res.value_byte};
    assign m_axis_tuser = {out_res.value_valid, out_res.status};
    assign m_axis_tlast = out_res.value_last;

endmodule
